/* rtl/rve_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// RV32 R-type execute package
// Transaction types, field constants and operation codes shared by the
// execute unit and its users.
// ----------------------------------------------------------------------------
package rve_pkg;

   localparam int unsigned XLEN      = 32;
   localparam int unsigned REG_COUNT = 32;
   localparam int unsigned REG_IDX_W = $clog2(REG_COUNT);
   localparam logic [XLEN-1:0] PC_STEP = XLEN'(4);

   // Transaction kinds.
   localparam logic ACTION_EXECUTE = 1'b0;
   localparam logic ACTION_LOAD    = 1'b1;

   // funct7 values.
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   // funct3 values.
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SRL  = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   typedef struct packed {
      logic                 action;
      logic [XLEN-1:0]      instruction_word;
      logic [REG_IDX_W-1:0] load_index;
      logic [XLEN-1:0]      load_value;
   } req_type;

   typedef struct packed {
      logic                 write_done;
      logic [REG_IDX_W-1:0] dest_index;
      logic [XLEN-1:0]      dest_value;
      logic                 illegal;
      logic [XLEN-1:0]      program_counter;
   } rsp_type;

endpackage
`default_nettype wire

/* rtl/rv32_rtype_execute.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// RV32 R-type execute unit
// Executes R-type instructions or direct register loads against a 32-entry
// register file held in a synchronous two-read, one-write memory.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while the response side does not stall;
// the register file read issues on acceptance and the ALU result is written back
// as the transaction leaves the execute stage, with the most recent write
// forwarded to the operands of the following transaction.
// Reset: program counter cleared, all registers read as zero (per-entry valid
// bits), no clearing pass; the unit accepts requests right after reset.
module rv32_rtype_execute (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rve_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rve_pkg::rsp_type      rsp_payload
);
   import rve_pkg::*;

   // Register file storage.
   logic [XLEN-1:0]      mem [REG_COUNT];
   logic [REG_COUNT-1:0] reg_valid_ff;
   logic [REG_COUNT-1:0] reg_valid_in;

   // Execute stage.
   logic                 s1_valid_ff, s1_valid_in;
   req_type              s1_req_ff;
   logic [XLEN-1:0]      rd_a_ff, rd_b_ff;

   // Last write, forwarded to the next transaction's operands.
   logic                 byp_valid_ff, byp_valid_in;
   logic [REG_IDX_W-1:0] byp_idx_ff;
   logic [XLEN-1:0]      byp_val_ff;

   logic [XLEN-1:0]      pc_ff, pc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff;

   logic                 req_take;
   logic                 s1_adv;
   logic [6:0]           f7;
   logic [2:0]           f3;
   logic [REG_IDX_W-1:0] rs1, rs2, rd;
   logic [XLEN-1:0]      op_a, op_b, alu_res;
   logic                 alu_ok;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] wr_idx;
   logic [XLEN-1:0]      wr_val;
   rsp_type              rsp_next;

   function automatic logic [XLEN-1:0] operand(
      input logic [REG_IDX_W-1:0] idx,
      input logic [XLEN-1:0]      mem_val,
      input logic                 valid,
      input logic                 byp_hit,
      input logic [XLEN-1:0]      byp_val
   );
      logic [XLEN-1:0] val;
      if (idx == '0) begin
         val = '0;
      end else if (byp_hit) begin
         val = byp_val;
      end else if (valid) begin
         val = mem_val;
      end else begin
         val = '0;
      end
      return val;
   endfunction

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;

   assign f7  = s1_req_ff.instruction_word[31:25];
   assign rs2 = s1_req_ff.instruction_word[24:20];
   assign rs1 = s1_req_ff.instruction_word[19:15];
   assign f3  = s1_req_ff.instruction_word[14:12];
   assign rd  = s1_req_ff.instruction_word[11:7];

   assign op_a = operand(rs1, rd_a_ff, reg_valid_ff[rs1],
                         byp_valid_ff && (byp_idx_ff == rs1), byp_val_ff);
   assign op_b = operand(rs2, rd_b_ff, reg_valid_ff[rs2],
                         byp_valid_ff && (byp_idx_ff == rs2), byp_val_ff);

   always_comb begin
      alu_res = '0;
      alu_ok  = 1'b0;
      if (f7 == F7_BASE) begin
         alu_ok = 1'b1;
         unique case (f3)
            F3_ADD:  alu_res = op_a + op_b;
            F3_SLL:  alu_res = op_a << op_b[4:0];
            F3_SLT:  alu_res = XLEN'($signed(op_a) < $signed(op_b));
            F3_SLTU: alu_res = XLEN'(op_a < op_b);
            F3_XOR:  alu_res = op_a ^ op_b;
            F3_SRL:  alu_res = op_a >> op_b[4:0];
            F3_OR:   alu_res = op_a | op_b;
            F3_AND:  alu_res = op_a & op_b;
            default: alu_ok  = 1'b0;
         endcase
      end else if (f7 == F7_ALT) begin
         if (f3 == F3_ADD) begin
            alu_ok  = 1'b1;
            alu_res = op_a - op_b;
         end else if (f3 == F3_SRL) begin
            alu_ok  = 1'b1;
            alu_res = XLEN'($signed(op_a) >>> op_b[4:0]);
         end
      end
   end

   always_comb begin
      wr_en    = 1'b0;
      wr_idx   = '0;
      wr_val   = '0;
      pc_in    = pc_ff;
      rsp_next = '0;
      if (s1_req_ff.action == ACTION_LOAD) begin
         if (s1_req_ff.load_index != '0) begin
            wr_en  = 1'b1;
            wr_idx = s1_req_ff.load_index;
            wr_val = s1_req_ff.load_value;
         end
      end else begin
         pc_in = pc_ff + PC_STEP;
         if (!alu_ok) begin
            rsp_next.illegal = 1'b1;
         end else if (rd != '0) begin
            wr_en  = 1'b1;
            wr_idx = rd;
            wr_val = alu_res;
         end
      end
      rsp_next.write_done      = wr_en;
      rsp_next.dest_index      = wr_idx;
      rsp_next.dest_value      = wr_val;
      rsp_next.program_counter = pc_in;
   end

   always_comb begin
      reg_valid_in = reg_valid_ff;
      byp_valid_in = byp_valid_ff;
      if (s1_adv && wr_en) begin
         reg_valid_in[wr_idx] = 1'b1;
         byp_valid_in         = 1'b1;
      end
      s1_valid_in  = req_take || req_stall;
      rsp_valid_in = s1_adv || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (s1_adv && wr_en) begin
         mem[wr_idx] <= wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rd_a_ff   <= mem[req_payload.instruction_word[19:15]];
         rd_b_ff   <= mem[req_payload.instruction_word[24:20]];
         s1_req_ff <= req_payload;
      end
      if (s1_adv && wr_en) begin
         byp_idx_ff <= wr_idx;
         byp_val_ff <= wr_val;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_valid_ff <= 1'b0;
         reg_valid_ff <= '0;
         pc_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         byp_valid_ff <= byp_valid_in;
         reg_valid_ff <= reg_valid_in;
         if (s1_adv) begin
            pc_ff <= pc_in;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Register zero is never written.
   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.write_done |-> rsp_payload.dest_index != '0)
      else $error("write to register zero reported");

   // An illegal operation writes nothing.
   a_illegal_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.illegal |-> !rsp_payload.write_done)
      else $error("illegal operation reported a write");

   // The request side only stalls behind an occupied execute stage.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled without a blocked execute stage");

   // A transaction leaving execute is shown as a response in the next cycle.
   a_s1_follow: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid)
      else $error("execute stage advanced without producing a response");

endmodule
`default_nettype wire
